/* sv/rftc_pkg.sv */
// Package: shared types, constants and helpers for the rational frame time converter.
`default_nettype none
package rftc_pkg;

    // Nanoseconds per second, fits in 30 bits
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // Number of restoring division steps, one per quotient bit
    localparam int DIV_STEPS = 64;

    // Configuration register indexes
    localparam logic REG_RATE_NUM = 1'b0;
    localparam logic REG_RATE_DEN = 1'b1;

    // Operation codes carried with every item
    typedef enum logic [1:0] {
        OP_INDEX_TO_TIME = 2'd0,
        OP_FLOOR_COUNT   = 2'd1,
        OP_CEIL_COUNT    = 2'd2,
        OP_MIN_DURATION  = 2'd3
    } op_t;

    // Product leaving the multiplier stages
    typedef struct packed {
        op_t          op;
        logic [127:0] prod;
    } mul_data_t;

    // Payload handed from one divider cell to the next
    typedef struct packed {
        op_t         op;
        logic        sat;
        logic [63:0] rem;
        logic [63:0] low;
        logic [63:0] quo;
    } div_data_t;

    // Count conversions divide by the period, time conversions by the numerator
    function automatic logic [63:0] divisor_sel(op_t op, logic [31:0] num,
                                                logic [61:0] period);
        logic [63:0] d;
        if (op == OP_FLOOR_COUNT || op == OP_CEIL_COUNT)
            d = {2'b00, period};
        else
            d = {32'd0, num};
        return d;
    endfunction

    // Count conversions multiply by the numerator, time conversions by the period
    function automatic logic [61:0] factor_sel(op_t op, logic [31:0] num,
                                               logic [61:0] period);
        logic [61:0] m;
        if (op == OP_FLOOR_COUNT || op == OP_CEIL_COUNT)
            m = {30'd0, num};
        else
            m = period;
        return m;
    endfunction

endpackage
`default_nettype wire

/* sv/rftc_channels.sv */
// Interfaces: request, result and configuration channels of the converter.
`default_nettype none
interface rftc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] operand_value;
    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink (input valid, input req_type, input operand_value, output ready);
endinterface

interface rftc_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic        saturated;
    modport source (output valid, output result_value, output saturated, input ready);
    modport sink (input valid, input result_value, input saturated, output ready);
endinterface

interface rftc_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

/* sv/rftc_mul.sv */
// Two-stage multiplier: operand times rate factor, 32x32 partial products.
`default_nettype none
module rftc_mul
    import rftc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [31:0] num,
    input  wire logic [61:0] period,
    input  wire logic        in_valid,
    input  wire op_t         in_op,
    input  wire logic [63:0] in_operand,
    output logic             out_valid,
    output mul_data_t        out_data
);

    logic [61:0]  factor;
    logic [63:0]  pp_ll;
    logic [63:0]  pp_hl;
    logic [95:0]  lo_next;
    logic         s1_valid_reg;
    op_t          s1_op_reg;
    logic [63:0]  s1_a_reg;
    logic [29:0]  s1_mhi_reg;
    logic [95:0]  s1_lo_reg;
    logic [63:0]  pp_lh;
    logic [63:0]  pp_hh;
    logic [95:0]  hi_sum;
    mul_data_t    s2_next;
    logic         s2_valid_reg;
    mul_data_t    s2_data_reg;

    // Stage one: operand times low half of the factor
    always_comb
    begin
        factor  = factor_sel(in_op, num, period);
        pp_ll   = 64'(in_operand[31:0]) * 64'(factor[31:0]);
        pp_hl   = 64'(in_operand[63:32]) * 64'(factor[31:0]);
        lo_next = 96'(pp_ll) + {pp_hl, 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg  <= in_op;
            s1_a_reg   <= in_operand;
            s1_mhi_reg <= factor[61:32];
            s1_lo_reg  <= lo_next;
        end
    end

    // Stage two: operand times high half of the factor, then merge
    always_comb
    begin
        pp_lh        = 64'(s1_a_reg[31:0]) * 64'(s1_mhi_reg);
        pp_hh        = 64'(s1_a_reg[63:32]) * 64'(s1_mhi_reg);
        hi_sum       = 96'(pp_lh) + {pp_hh, 32'd0};
        s2_next.op   = s1_op_reg;
        s2_next.prod = 128'(s1_lo_reg) + {hi_sum, 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_data_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule
`default_nettype wire

/* sv/rftc_div_cell.sv */
// Divider cell: one restoring division step, one quotient bit per cell.
`default_nettype none
module rftc_div_cell
    import rftc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [31:0] num,
    input  wire logic [61:0] period,
    input  wire logic        in_valid,
    input  wire div_data_t   in_data,
    output logic             out_valid,
    output div_data_t        out_data
);

    logic [63:0] divisor;
    logic [63:0] rem_sh;
    logic        ge;
    div_data_t   data_next;
    logic        valid_reg;
    div_data_t   data_reg;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        divisor        = divisor_sel(in_data.op, num, period);
        rem_sh         = {in_data.rem[62:0], in_data.low[63]};
        ge             = (rem_sh >= divisor);
        data_next      = in_data;
        data_next.rem  = ge ? (rem_sh - divisor) : rem_sh;
        data_next.low  = {in_data.low[62:0], 1'b0};
        data_next.quo  = {in_data.quo[62:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* sv/rational_frame_time_converter.sv */
// Top level: rational frame/time converter with a pipelined divider chain.
// Usage:
//   cfg channel writes rate_numerator (index 0) and rate_denominator (index 1);
//   it is always ready. Write it only while no item is in flight.
//   req channel takes req_type and operand_value; res channel returns
//   result_value and saturated, one result item per request item, in order.
// Throughput: one item per cycle while the result side is not stalled.
// Pipeline: 68 register stages: two multiplier stages (32x32 partial products),
//   one load stage with the overflow check, 64 divider cells (one quotient bit
//   each) and the output register; the first stage loads at the accepting
//   edge.
// Stall: when the result waits and res.ready is low, the whole pipeline
//   holds and req.ready drops; nothing is lost or repeated.
// Reset: the pipeline empties, the rate returns to 30 frames per 1 second.
// Saturation: results that overflow 64 bits, or any request while either
//   rate register is zero, return all ones with saturated set.
`default_nettype none
module rational_frame_time_converter
    import rftc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rftc_cfg_if.sink   cfg,
    rftc_req_if.sink   req,
    rftc_res_if.source res
);

    logic [31:0]  num_reg;
    logic [61:0]  period_reg;
    logic [61:0]  period_next;
    logic         en;
    logic         mul_valid;
    mul_data_t    mul_data;
    logic [63:0]  load_div;
    div_data_t    load_next;
    logic         load_valid_reg;
    div_data_t    load_data_reg;
    logic         cell_valid [DIV_STEPS+1];
    div_data_t    cell_data [DIV_STEPS+1];
    div_data_t    fin;
    logic [63:0]  result_next;
    logic         res_valid_reg;
    logic [63:0]  res_value_reg;
    logic         res_sat_reg;

    // Hold rate registers; keep the period in nanoseconds precomputed
    assign cfg.ready   = 1'b1;
    assign period_next = 62'(64'(cfg.wdata) * 64'(NS_PER_SEC));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg    <= 32'd30;
            period_reg <= 62'(NS_PER_SEC);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_RATE_NUM)
                num_reg <= cfg.wdata;
            else
                period_reg <= period_next;
        end
    end

    // Advance the pipeline unless the result waits
    assign en        = !res_valid_reg || res.ready;
    assign req.ready = en;

    rftc_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .num        (num_reg),
        .period     (period_reg),
        .in_valid   (req.valid),
        .in_op      (op_t'(req.req_type)),
        .in_operand (req.operand_value),
        .out_valid  (mul_valid),
        .out_data   (mul_data)
    );

    // Load the divider: flag overflow of the quotient or a zero rate
    always_comb
    begin
        load_div      = divisor_sel(mul_data.op, num_reg, period_reg);
        load_next.op  = mul_data.op;
        load_next.sat = (num_reg == 32'd0) || (period_reg == 62'd0)
                        || (mul_data.prod[127:64] >= load_div);
        load_next.rem = mul_data.prod[127:64];
        load_next.low = mul_data.prod[63:0];
        load_next.quo = 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_valid_reg <= 1'b0;
        else if (en)
            load_valid_reg <= mul_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            load_data_reg <= load_next;
    end

    assign cell_valid[0] = load_valid_reg;
    assign cell_data[0]  = load_data_reg;

    // Chain of divider cells, one quotient bit each
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_cell
        rftc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .num       (num_reg),
            .period    (period_reg),
            .in_valid  (cell_valid[k]),
            .in_data   (cell_data[k]),
            .out_valid (cell_valid[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    // Finish: saturate, or round up by the remainder per operation
    always_comb
    begin
        fin = cell_data[DIV_STEPS];
        unique case (fin.op)
            OP_INDEX_TO_TIME,
            OP_FLOOR_COUNT:
                result_next = fin.sat ? '1 : fin.quo;
            OP_CEIL_COUNT:
                if (fin.sat || fin.quo == '1)
                    result_next = '1;
                else
                    result_next = fin.quo + 64'(fin.rem >= {32'd0, num_reg});
            OP_MIN_DURATION:
                if (fin.sat || fin.quo == '1)
                    result_next = '1;
                else
                    result_next = fin.quo + 64'(fin.rem != 64'd0);
            default:
                result_next = '1;
        endcase
    end

    // Output register parts the result side from the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= cell_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_value_reg <= result_next;
            res_sat_reg   <= (result_next == '1);
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.result_value = res_value_reg;
    assign res.saturated    = res_sat_reg;

endmodule
`default_nettype wire

/* tb/tb_rational_frame_time_converter.sv */
// Testbench: drives conversions through the rational frame time converter and checks each result.
`default_nettype none
module tb_rational_frame_time_converter
    import rftc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam longint unsigned CYCLE_LIMIT = 2000000;
    localparam int PIPE_DEPTH = 68;

    typedef struct {
        logic [63:0] value;
        logic        sat;
    } conv_result_t;

    logic clk;
    logic rst_n;
    rftc_cfg_if cfg ();
    rftc_req_if req ();
    rftc_res_if res ();

    rational_frame_time_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );

    // Predictor copy of the rate registers
    logic [31:0] rate_num;
    logic [31:0] rate_den;

    conv_result_t pending_results[$];
    bit           failed;
    bit           stall_enable;
    int           stall_left;
    longint unsigned cycle_count;

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // floor(a * b / d); all ones when the quotient needs more than 64 bits
    function automatic logic [63:0] scale_floor(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] d);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if (prod[127:64] >= d)
            return ALL_ONES;
        return 64'(prod / {64'd0, d});
    endfunction

    function automatic logic [63:0] frame_time(logic [63:0] idx, logic [63:0] num,
                                               logic [63:0] period);
        logic [63:0]  whole;
        logic [127:0] base;
        logic [63:0]  tail;
        logic [64:0]  total;
        whole = idx / num;
        base = {64'd0, whole} * {64'd0, period};
        if (base[127:64] != 0)
            return ALL_ONES;
        tail = scale_floor(period, idx % num, num);
        total = {1'b0, base[63:0]} + {1'b0, tail};
        if (total[64])
            return ALL_ONES;
        return total[63:0];
    endfunction

    function automatic logic [63:0] shortest_span(logic [63:0] count, logic [63:0] num,
                                                  logic [63:0] period);
        logic [63:0] t;
        t = frame_time(count, num, period);
        if (t != ALL_ONES && scale_floor(t, num, period) < count)
            t = t + 64'd1;
        return t;
    endfunction

    function automatic conv_result_t convert(op_t op, logic [63:0] v);
        conv_result_t r;
        logic [63:0] num;
        logic [63:0] period;
        logic [63:0] f;
        num = {32'd0, rate_num};
        period = 64'd1000000000 * {32'd0, rate_den};
        if (num == 0 || period == 0)
            r.value = ALL_ONES;
        else
        begin
            case (op)
                OP_INDEX_TO_TIME: r.value = frame_time(v, num, period);
                OP_FLOOR_COUNT:   r.value = scale_floor(v, num, period);
                OP_CEIL_COUNT:
                begin
                    f = scale_floor(v, num, period);
                    if (f == ALL_ONES)
                        r.value = f;
                    else
                        r.value = (shortest_span(f, num, period) < v) ? f + 64'd1 : f;
                end
                default:          r.value = shortest_span(v, num, period);
            endcase
        end
        r.sat = (r.value == ALL_ONES);
        return r;
    endfunction

    // Send one conversion and queue its prediction
    task automatic send_request(op_t op, logic [63:0] v);
        if (stall_enable && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 10)) @(negedge clk);
        req.valid = 1'b1;
        req.req_type = op;
        req.operand_value = v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), convert(op, v));
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    // Wait for the pipeline to drain, then write one rate register
    task automatic write_rate(logic idx, logic [31:0] value);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == REG_RATE_NUM)
            rate_num = value;
        else
            rate_den = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = {32'd0, v[31:0]};
            2: v = {48'd0, v[15:0]};
            3: v = ALL_ONES - {56'd0, v[7:0]};
            default: ;
        endcase
        return v;
    endfunction

    task automatic run_directed_default();
        send_request(OP_INDEX_TO_TIME, 64'd0);
        send_request(OP_INDEX_TO_TIME, 64'd29);
        send_request(OP_INDEX_TO_TIME, 64'd31);
        send_request(OP_INDEX_TO_TIME, ALL_ONES);
        send_request(OP_FLOOR_COUNT, 64'd0);
        send_request(OP_FLOOR_COUNT, 64'd1000000000);
        send_request(OP_FLOOR_COUNT, ALL_ONES);
        send_request(OP_CEIL_COUNT, 64'd1);
        send_request(OP_CEIL_COUNT, 64'd33333334);
        send_request(OP_CEIL_COUNT, ALL_ONES);
        send_request(OP_MIN_DURATION, 64'd1);
        send_request(OP_MIN_DURATION, 64'd7);
        send_request(OP_MIN_DURATION, ALL_ONES);
    endtask

    // Extreme rates, zero registers and the unity rate that yields exact all ones
    task automatic run_directed_rates();
        write_rate(REG_RATE_NUM, 32'hffff_ffff);
        write_rate(REG_RATE_DEN, 32'd1);
        send_request(OP_FLOOR_COUNT, ALL_ONES);
        send_request(OP_INDEX_TO_TIME, ALL_ONES);
        write_rate(REG_RATE_DEN, 32'hffff_ffff);
        send_request(OP_INDEX_TO_TIME, ALL_ONES);
        send_request(OP_CEIL_COUNT, ALL_ONES);
        write_rate(REG_RATE_NUM, 32'd1000000000);
        write_rate(REG_RATE_DEN, 32'd1);
        send_request(OP_FLOOR_COUNT, ALL_ONES);
        send_request(OP_MIN_DURATION, ALL_ONES);
        write_rate(REG_RATE_NUM, 32'd0);
        send_request(OP_FLOOR_COUNT, 64'd5);
        send_request(OP_INDEX_TO_TIME, 64'd5);
        write_rate(REG_RATE_NUM, 32'd25);
        write_rate(REG_RATE_DEN, 32'd0);
        send_request(OP_MIN_DURATION, 64'd5);
        send_request(OP_CEIL_COUNT, 64'd5);
    endtask

    task automatic run_random_phase(logic [31:0] num, logic [31:0] den, int count);
        write_rate(REG_RATE_NUM, num);
        write_rate(REG_RATE_DEN, den);
        repeat (count)
            send_request(op_t'($urandom_range(0, 3)), random_operand());
    endtask

    task automatic run_drain_pause();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3)
            send_request(op_t'($urandom_range(0, 3)), random_operand());
    endtask

    // Result stall in random bursts
    always @(negedge clk)
    begin
        if (!stall_enable || !rst_n)
        begin
            res.ready <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            res.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            res.ready <= 1'b0;
            stall_left <= int'($urandom_range(0, 9));
        end
        else
            res.ready <= 1'b1;
    end

    // Compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        conv_result_t exp_r;
        cycle_count <= cycle_count + 1;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%t: unexpected result value=%h sat=%b", $time,
                         res.result_value, res.saturated);
                failed = 1'b1;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (res.result_value !== exp_r.value)
                begin
                    $display("%t: result_value expected %h actual %h", $time,
                             exp_r.value, res.result_value);
                    failed = 1'b1;
                end
                if (res.saturated !== exp_r.sat)
                begin
                    $display("%t: saturated expected %b actual %b", $time,
                             exp_r.sat, res.saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        failed = 1'b0;
        stall_enable = 1'b1;
        cycle_count = 0;
        rate_num = 32'd30;
        rate_den = 32'd1;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_RATE_NUM;
        cfg.wdata = '0;
        req.valid = 1'b0;
        req.req_type = OP_INDEX_TO_TIME;
        req.operand_value = '0;
        res.ready = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed_default();
        run_directed_rates();
        run_random_phase(32'd30, 32'd1, 200);
        run_drain_pause();
        run_random_phase(32'd30000, 32'd1001, 200);
        run_random_phase(32'hffff_ffff, 32'hffff_ffff, 150);
        run_random_phase(32'd1, 32'hffff_ffff, 150);
        run_random_phase($urandom(), $urandom_range(1, 100), 200);
        run_random_phase($urandom_range(1, 1000), $urandom(), 150);
        stall_enable = 1'b0;
        run_random_phase(32'd24, 32'd1, 150);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 10) @(negedge clk);
        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* rational_frame_time_converter.f */
sv/rftc_pkg.sv
sv/rftc_channels.sv
sv/rftc_mul.sv
sv/rftc_div_cell.sv
sv/rational_frame_time_converter.sv
tb/tb_rational_frame_time_converter.sv
